/* src/kct_pkg.sv */
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and codes for the keyed count table: operation kinds,
// result status codes, widths of the result fields and the control states.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int KEY_W   = 32;
    localparam int QTY_W   = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int USED_W  = 7;

    // Operation kinds. The fourth code is not an operation.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

    localparam logic signed [QTY_W-1:0] QTY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QTY_W-1:0] QTY_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

/* src/kct_if.sv */
// ----------------------------------------------------------------------------
// kct request and response channels
// Valid/ready channels of the keyed count table: one carries request items,
// the other carries result items.
// ----------------------------------------------------------------------------
interface kct_req_if
    import kct_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [KEY_W-1:0]  key;
    logic signed [QTY_W-1:0]  amount;

    modport source (output valid, output kind, output key, output amount, input ready);
    modport sink   (input valid, input kind, input key, input amount, output ready);
endinterface

interface kct_rsp_if
    import kct_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [QTY_W-1:0]  quantity;
    logic [USED_W-1:0]        entries_used;

    modport source (output valid, output status, output quantity, output entries_used,
                    input ready);
    modport sink   (input valid, input status, input quantity, input entries_used,
                    output ready);
endinterface

/* src/keyed_count_table_unit.sv */
// ----------------------------------------------------------------------------
// keyed_count_table_unit
// Table of unique keys with saturating signed quantities, kept in two RAMs
// and searched by a linear scan that reads one entry per cycle.
// ----------------------------------------------------------------------------
// Flow: a key found in the scan gives its result from the result state once
// the compare hits; a miss gives it after the last entry is compared. A
// full-table insert, an unknown kind or a request on an empty table skips the
// scan and goes to the result state directly. One item at a time: the next
// request is taken once the result sits in the output register.
// Reset empties the table at once (no clearing pass).
module keyed_count_table_unit
    import kct_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    kct_req_if.sink   req,
    kct_rsp_if.source rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [QTY_W-1:0]        amount_reg, amount_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    pend_last_reg, pend_last_next;
    logic [AW-1:0]           pend_idx_reg, pend_idx_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic [QTY_W-1:0]        res_qty_reg, res_qty_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic [QTY_W-1:0]        out_qty_reg, out_qty_next;
    logic [USED_W-1:0]       out_used_reg, out_used_next;

    logic                    accept;
    logic                    out_free;
    logic                    is_full;
    logic                    issue;
    logic                    hit;
    logic                    miss;
    logic [CW-1:0]           last_idx;
    logic [KEY_W-1:0]        rd_key;
    logic [QTY_W-1:0]        rd_qty;
    logic signed [QTY_W:0]   sum_wide;
    logic [QTY_W-1:0]        sum_sat;
    logic [31:0]             count_wide;

    logic                    key_wr_en;
    logic                    qty_wr_en;
    logic [AW-1:0]           wr_addr;
    logic [KEY_W-1:0]        key_wr_data;
    logic [QTY_W-1:0]        qty_wr_data;

    kct_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_key)
    );

    kct_ram #(.WIDTH(QTY_W), .DEPTH(TABLE_DEPTH)) u_qty_ram (
        .clk     (clk),
        .wr_en   (qty_wr_en),
        .wr_addr (wr_addr),
        .wr_data (qty_wr_data),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_qty)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign accept           = req.valid && req.ready;
    assign out_free         = !out_valid_reg || rsp.ready;
    assign is_full          = (count_reg == CW'(TABLE_DEPTH));
    assign last_idx         = count_reg - 1'b1;
    assign issue            = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
    assign hit              = pend_valid_reg && (rd_key == key_reg);
    assign miss             = pend_valid_reg && !hit && pend_last_reg;

    // Saturating add of the stored quantity and the change.
    assign sum_wide = {rd_qty[QTY_W-1], rd_qty} + {amount_reg[QTY_W-1], amount_reg};
    assign sum_sat  = (sum_wide[QTY_W] != sum_wide[QTY_W-1])
                      ? (sum_wide[QTY_W] ? QTY_MIN : QTY_MAX)
                      : sum_wide[QTY_W-1:0];

    assign count_wide       = 32'(count_reg);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.quantity     = out_qty_reg;
    assign rsp.entries_used = out_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        amount_reg     <= amount_next;
        rd_idx_reg     <= rd_idx_next;
        pend_last_reg  <= pend_last_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_qty_reg    <= res_qty_next;
        out_status_reg <= out_status_next;
        out_qty_reg    <= out_qty_next;
        out_used_reg   <= out_used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        amount_next     = amount_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = 1'b0;
        pend_last_next  = pend_last_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_qty_next    = res_qty_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_qty_next    = out_qty_reg;
        out_used_next   = out_used_reg;
        key_wr_en       = 1'b0;
        qty_wr_en       = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        key_wr_data     = key_reg;
        qty_wr_data     = amount_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = req.kind;
                    key_next     = req.key;
                    amount_next  = req.amount;
                    rd_idx_next  = '0;
                    res_qty_next = '0;
                    state_next   = S_RESULT;
                    if (req.kind == KIND_INSERT && is_full)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else if (req.kind != KIND_INSERT && req.kind != KIND_SEARCH &&
                             req.kind != KIND_UPDATE)
                    begin
                        res_status_next = STAT_ABSENT;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty table: every lookup misses without a scan.
                        if (req.kind == KIND_INSERT)
                        begin
                            key_wr_en       = 1'b1;
                            qty_wr_en       = 1'b1;
                            key_wr_data     = req.key;
                            qty_wr_data     = req.amount;
                            count_next      = count_reg + 1'b1;
                            res_status_next = STAT_OK;
                            res_qty_next    = req.amount;
                        end
                        else
                        begin
                            res_status_next = STAT_ABSENT;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads are issued one entry ahead of the compare.
                if (issue)
                begin
                    rd_idx_next     = rd_idx_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_last_next  = (rd_idx_reg == last_idx);
                    pend_idx_next   = rd_idx_reg[AW-1:0];
                end
                if (hit)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_RESULT;
                    res_qty_next    = '0;
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            res_status_next = STAT_DUP;
                        end
                        KIND_SEARCH:
                        begin
                            res_status_next = STAT_OK;
                            res_qty_next    = rd_qty;
                        end
                        KIND_UPDATE:
                        begin
                            qty_wr_en       = 1'b1;
                            wr_addr         = pend_idx_reg;
                            qty_wr_data     = sum_sat;
                            res_status_next = STAT_OK;
                            res_qty_next    = sum_sat;
                        end
                        default:
                        begin
                            res_status_next = STAT_ABSENT;
                        end
                    endcase
                end
                else if (miss)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_RESULT;
                    res_qty_next    = '0;
                    if (kind_reg == KIND_INSERT)
                    begin
                        key_wr_en       = 1'b1;
                        qty_wr_en       = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = STAT_OK;
                        res_qty_next    = amount_reg;
                    end
                    else
                    begin
                        res_status_next = STAT_ABSENT;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_qty_next    = res_qty_reg;
                    out_used_next   = count_wide[USED_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count changed by other than one");

    a_grow_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |-> (key_wr_en && qty_wr_en))
        else $error("entry count grew without a table write");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_SCAN))
        else $error("pending compare outside of a scan");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_RESULT))
        else $error("result issued without passing the result state");

endmodule

/* src/kct_ram.sv */
// ----------------------------------------------------------------------------
// kct_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
